@@ rtl/core/r5sbd_pkg.sv @@
// ---------------------------------------------------------------------------
// r5sbd_pkg
// Shared widths, reset values and result codes of the RAID-5 stripe block
// distributor.
// ---------------------------------------------------------------------------
package r5sbd_pkg;

   localparam int LBA_W          = 12;
   localparam int CSR_W          = 5;
   localparam int DISK_OUT_W     = 4;
   localparam int STRIPE_OUT_W   = 12;
   localparam int KIND_W         = 2;
   localparam int DISK_COUNT_RST = 4;
   localparam int CSR_MIN_DISKS  = 2;

   // Largest quotient of a sector address by the smallest legal map size
   // fits in this many bits, so the index reduction needs this many steps.
   localparam int IDX_RED_STEPS  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_UPDATE = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_PARITY = 2'd2
   } kind_type;

endpackage

@@ rtl/core/r5sbd_map.sv @@
// ---------------------------------------------------------------------------
// r5sbd_map
// Logical-to-physical sector map: one memory with a registered read, a
// write-to-read bypass and a clearing pass after reset.
// ---------------------------------------------------------------------------
module r5sbd_map
   import r5sbd_pkg::*;
#(
   parameter int MAP_ENTRIES = 4096,
   parameter int DW          = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           lookup_en,
   input  logic [LBA_W-1:0]               lookup_lba,
   input  logic                           upd_en,
   input  logic [DW-1:0]                  upd_disk,
   input  logic [$clog2(MAP_ENTRIES)-1:0] upd_stripe,
   output logic                           hit_valid,
   output logic [DW-1:0]                  hit_disk,
   output logic [$clog2(MAP_ENTRIES)-1:0] hit_stripe,
   output logic                           clearing
);

   localparam int AW = $clog2(MAP_ENTRIES);
   localparam int EW = 1 + DW + AW;

   logic [EW-1:0] mem [MAP_ENTRIES];

   logic [LBA_W-1:0] red_lba;
   logic [AW-1:0]    lookup_idx;
   logic [AW-1:0]    idx_ff;
   logic [EW-1:0]    rd_ff;
   logic             byp_ff;
   logic             byp_in;
   logic [EW-1:0]    byp_data_ff;
   logic             clr_ff;
   logic             clr_in;
   logic [AW-1:0]    clr_addr_ff;
   logic [AW-1:0]    clr_addr_in;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic [EW-1:0]    entry;

   // The sector address is reduced modulo the map size by restoring
   // subtraction of shifted copies of the size, largest first.
   always_comb begin
      red_lba = lookup_lba;
      for (int k = IDX_RED_STEPS - 1; k >= 0; k--) begin
         if (32'(red_lba) >= (32'(MAP_ENTRIES) << k)) begin
            red_lba = red_lba - LBA_W'(32'(MAP_ENTRIES) << k);
         end
      end
   end

   assign lookup_idx = AW'(red_lba);

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == AW'(MAP_ENTRIES - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   assign wr_en   = clr_ff | upd_en;
   assign wr_addr = clr_ff ? clr_addr_ff : idx_ff;
   assign wr_data = clr_ff ? '0 : {1'b1, upd_disk, upd_stripe};

   // A lookup of the entry that is written at the same edge takes the new
   // contents instead of the stale memory word.
   assign byp_in = upd_en & (lookup_idx == idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         rd_ff       <= mem[lookup_idx];
         idx_ff      <= lookup_idx;
         byp_ff      <= byp_in;
         byp_data_ff <= wr_data;
      end
   end

   assign entry      = byp_ff ? byp_data_ff : rd_ff;
   assign hit_valid  = entry[EW-1];
   assign hit_disk   = entry[EW-2 -: DW];
   assign hit_stripe = entry[AW-1:0];
   assign clearing   = clr_ff;

   a_no_lookup_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !lookup_en)
      else $error("map lookup during clearing pass");

   a_no_update_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !upd_en)
      else $error("map update during clearing pass");

endmodule

@@ rtl/core/r5sbd_place.sv @@
// ---------------------------------------------------------------------------
// r5sbd_place
// Rotating parity placement: disk count register, rotation state, the
// per-sector decision and the result register.
// ---------------------------------------------------------------------------
module r5sbd_place
   import r5sbd_pkg::*;
#(
   parameter int MAP_ENTRIES = 4096,
   parameter int MAX_DISKS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           csr_we,
   input  logic [CSR_W-1:0]               csr_wdata,
   input  logic                           hit_valid,
   input  logic [$clog2(MAX_DISKS)-1:0]   hit_disk,
   input  logic [$clog2(MAP_ENTRIES)-1:0] hit_stripe,
   output logic                           upd_en,
   output logic [$clog2(MAX_DISKS)-1:0]   upd_disk,
   output logic [$clog2(MAP_ENTRIES)-1:0] upd_stripe,
   output logic                           stall,
   output logic                           rsp_valid,
   output logic [DISK_OUT_W-1:0]          rsp_disk,
   output logic [STRIPE_OUT_W-1:0]        rsp_stripe,
   output logic [KIND_W-1:0]              rsp_kind,
   output logic                           rsp_last
);

   localparam int DW     = $clog2(MAX_DISKS);
   localparam int CW     = $clog2(MAX_DISKS + 1);
   localparam int AW     = $clog2(MAP_ENTRIES);
   localparam int NW     = DW + 2;
   localparam int DC_RST = (DISK_COUNT_RST > MAX_DISKS) ? MAX_DISKS : DISK_COUNT_RST;
   localparam int PAR_RST = DC_RST - 1;

   logic [CW-1:0]  dc_ff,     dc_in;
   logic [DW-1:0]  parity_ff, parity_in;
   logic [DW-1:0]  next_ff,   next_in;
   logic [AW-1:0]  stripe_ff, stripe_in;
   logic           s1_ff;
   logic           pend_ff,   pend_in;
   logic [DW-1:0]  pdisk_ff;
   logic [AW-1:0]  pstripe_ff;
   logic           rv_ff,     rv_in;
   logic [DW-1:0]  rdisk_ff,  rdisk_in;
   logic [AW-1:0]  rstripe_ff, rstripe_in;
   kind_type       rkind_ff,  rkind_in;
   logic           rlast_ff,  rlast_in;
   logic [NW-1:0]  nd;
   logic           full;
   logic [7:0]     csr_val;
   logic [DW-1:0]  new_parity;

   always_comb begin
      nd = NW'(next_ff) + NW'(1);
      if (nd == NW'(parity_ff)) begin
         nd = nd + NW'(1);
      end
      full = ~hit_valid & (nd >= NW'(dc_ff));
   end

   assign stall      = s1_ff & full;
   assign upd_en     = s1_ff & ~hit_valid;
   assign upd_disk   = next_ff;
   assign upd_stripe = stripe_ff;

   // A written disk count is clamped to the legal range.
   always_comb begin
      csr_val = 8'(csr_wdata);
      if (csr_val < 8'(CSR_MIN_DISKS)) begin
         csr_val = 8'(CSR_MIN_DISKS);
      end else if (csr_val > 8'(MAX_DISKS)) begin
         csr_val = 8'(MAX_DISKS);
      end
   end

   always_comb begin
      dc_in      = dc_ff;
      parity_in  = parity_ff;
      next_in    = next_ff;
      stripe_in  = stripe_ff;
      pend_in    = 1'b0;
      rv_in      = 1'b0;
      rdisk_in   = next_ff;
      rstripe_in = stripe_ff;
      rkind_in   = KIND_DATA;
      rlast_in   = 1'b1;
      new_parity = (parity_ff == '0) ? DW'(dc_ff - CW'(1)) : parity_ff - DW'(1);

      if (pend_ff) begin
         rv_in      = 1'b1;
         rdisk_in   = pdisk_ff;
         rstripe_in = pstripe_ff;
         rkind_in   = KIND_PARITY;
      end else if (s1_ff) begin
         rv_in = 1'b1;
         if (hit_valid) begin
            rdisk_in   = hit_disk;
            rstripe_in = hit_stripe;
            rkind_in   = KIND_UPDATE;
         end else if (!full) begin
            next_in = DW'(nd);
         end else begin
            // The stripe is complete: the parity transfer follows next cycle.
            rlast_in  = 1'b0;
            pend_in   = 1'b1;
            parity_in = new_parity;
            next_in   = (new_parity == '0) ? DW'(1) : '0;
            if ((AW + 1)'(stripe_ff) + (AW + 1)'(1) == (AW + 1)'(MAP_ENTRIES)) begin
               stripe_in = '0;
            end else begin
               stripe_in = stripe_ff + AW'(1);
            end
         end
      end

      // A disk count write restarts the rotation; map and stripe are kept.
      if (csr_we) begin
         dc_in     = CW'(csr_val);
         parity_in = DW'(csr_val - 8'd1);
         next_in   = (DW'(csr_val - 8'd1) == '0) ? DW'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff     <= CW'(DC_RST);
         parity_ff <= DW'(PAR_RST);
         next_ff   <= (PAR_RST == 0) ? DW'(1) : '0;
         stripe_ff <= '0;
         s1_ff     <= 1'b0;
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         dc_ff     <= dc_in;
         parity_ff <= parity_in;
         next_ff   <= next_in;
         stripe_ff <= stripe_in;
         s1_ff     <= accept;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_in) begin
         pdisk_ff   <= parity_ff;
         pstripe_ff <= stripe_ff;
      end
      rdisk_ff   <= rdisk_in;
      rstripe_ff <= rstripe_in;
      rkind_ff   <= rkind_in;
      rlast_ff   <= rlast_in;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_disk   = DISK_OUT_W'(rdisk_ff);
   assign rsp_stripe = STRIPE_OUT_W'(rstripe_ff);
   assign rsp_kind   = rkind_ff;
   assign rsp_last   = rlast_ff;

   a_pend_excludes_item: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !s1_ff)
      else $error("item decision collides with pending parity transfer");

   a_parity_follows_data: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rkind_ff == KIND_PARITY) |->
         $past(rv_ff && rkind_ff == KIND_DATA && !rlast_ff))
      else $error("parity transfer without preceding stripe-closing data transfer");

   a_rotation_in_range: assert property (@(posedge clock) disable iff (reset)
      (parity_ff < DW'(dc_ff - CW'(1)) || parity_ff == DW'(dc_ff - CW'(1)))
      && NW'(next_ff) < NW'(dc_ff) && next_ff != parity_ff)
      else $error("rotation state outside the disk count");

endmodule

@@ rtl/core/raid5_stripe_block_distributor.sv @@
// ---------------------------------------------------------------------------
// raid5_stripe_block_distributor
// Places logical sector writes on the disks of a RAID-5 array with rotating
// parity and issues data, update and parity block writes.
// ---------------------------------------------------------------------------
// Usage:
//   A sector write is taken when start is high and busy is low; req_lba is
//   sampled at that edge. Each result transfer is shown on the rsp_ ports for
//   exactly one cycle with rsp_valid high; the receiver cannot stall it.
//   The edge that takes the sector also reads the sector map, and the cycle
//   after it decides and loads the result register. A sector that closes a
//   stripe gives a data transfer with rsp_last low, followed in the next cycle
//   by the parity transfer. Throughput is one sector per cycle while busy is
//   low; a sector that closes a stripe holds busy high for one cycle. The
//   single map write port and the one result register set this rate.
//   The disk count is written through csr_we and csr_wdata while the block is
//   idle; a write restarts the parity rotation but keeps map and stripe.
//   After reset the map memory is cleared one entry per cycle, which keeps
//   busy high until the map is clear; disk count writes are taken meanwhile.
// ---------------------------------------------------------------------------
module raid5_stripe_block_distributor
   import r5sbd_pkg::*;
#(
   parameter int MAP_ENTRIES = 4096,
   parameter int MAX_DISKS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [LBA_W-1:0]        req_lba,
   output logic                    rsp_valid,
   output logic [DISK_OUT_W-1:0]   rsp_disk,
   output logic [STRIPE_OUT_W-1:0] rsp_stripe,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int DW = $clog2(MAX_DISKS);
   localparam int AW = $clog2(MAP_ENTRIES);

   logic          accept;
   logic          clearing;
   logic          stall;
   logic          hit_valid;
   logic [DW-1:0] hit_disk;
   logic [AW-1:0] hit_stripe;
   logic          upd_en;
   logic [DW-1:0] upd_disk;
   logic [AW-1:0] upd_stripe;

   assign busy   = clearing | stall;
   assign accept = start & ~busy;

   r5sbd_map #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .DW          (DW)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .lookup_en  (accept),
      .lookup_lba (req_lba),
      .upd_en     (upd_en),
      .upd_disk   (upd_disk),
      .upd_stripe (upd_stripe),
      .hit_valid  (hit_valid),
      .hit_disk   (hit_disk),
      .hit_stripe (hit_stripe),
      .clearing   (clearing)
   );

   r5sbd_place #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .MAX_DISKS   (MAX_DISKS)
   ) u_place (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .hit_valid  (hit_valid),
      .hit_disk   (hit_disk),
      .hit_stripe (hit_stripe),
      .upd_en     (upd_en),
      .upd_disk   (upd_disk),
      .upd_stripe (upd_stripe),
      .stall      (stall),
      .rsp_valid  (rsp_valid),
      .rsp_disk   (rsp_disk),
      .rsp_stripe (rsp_stripe),
      .rsp_kind   (rsp_kind),
      .rsp_last   (rsp_last)
   );

endmodule

@@ verif/tb_raid5_stripe_block_distributor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_raid5_stripe_block_distributor
// Drives sector writes into the RAID-5 stripe block distributor over several
// disk counts. A placement tracker predicts every data, update and parity
// transfer, and each result is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_raid5_stripe_block_distributor;
   import r5sbd_pkg::*;

   localparam int SECTORS      = 4096;
   localparam int MAX_DISKS    = 16;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_LIMIT  = 2000;

   typedef struct packed {
      logic [DISK_OUT_W-1:0]   disk;
      logic [STRIPE_OUT_W-1:0] stripe;
      kind_type                kind;
      logic                    last;
   } block_write_type;

   // Tracks the sector map and the parity rotation, and holds the block
   // writes that the distributor still owes.
   class placement_tracker_type;
      bit                      map_valid[SECTORS];
      logic [DISK_OUT_W-1:0]   map_disk[SECTORS];
      logic [STRIPE_OUT_W-1:0] map_stripe[SECTORS];
      int unsigned             disk_count;
      int unsigned             parity_disk;
      int unsigned             next_disk;
      logic [STRIPE_OUT_W-1:0] stripe_no;
      block_write_type         expected_writes[$];
      logic [LBA_W-1:0]        written_lbas[$];
      int                      fail_count;

      function new();
         fail_count = 0;
         stripe_no  = '0;
         set_disk_count(DISK_COUNT_RST);
      endfunction

      function void set_disk_count(int unsigned value);
         if (value < CSR_MIN_DISKS) value = CSR_MIN_DISKS;
         if (value > MAX_DISKS) value = MAX_DISKS;
         disk_count  = value;
         parity_disk = disk_count - 1;
         next_disk   = (parity_disk == 0) ? 1 : 0;
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10) $display("ERROR %0t: %s", $realtime, msg);
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void note_sector(logic [LBA_W-1:0] lba);
         int unsigned     nd;
         block_write_type w;
         if (map_valid[lba]) begin
            w = '{map_disk[lba], map_stripe[lba], KIND_UPDATE, 1'b1};
            expected_writes = {expected_writes, w};
            return;
         end
         map_valid[lba]  = 1'b1;
         map_disk[lba]   = next_disk[DISK_OUT_W-1:0];
         map_stripe[lba] = stripe_no;
         written_lbas = {written_lbas, lba};
         nd = next_disk + 1;
         if (nd == parity_disk) nd++;
         if (nd < disk_count) begin
            w = '{next_disk[DISK_OUT_W-1:0], stripe_no, KIND_DATA, 1'b1};
            expected_writes = {expected_writes, w};
            next_disk = nd;
            return;
         end
         // This sector closes the stripe, so the parity write follows it.
         w = '{next_disk[DISK_OUT_W-1:0], stripe_no, KIND_DATA, 1'b0};
         expected_writes = {expected_writes, w};
         w = '{parity_disk[DISK_OUT_W-1:0], stripe_no, KIND_PARITY, 1'b1};
         expected_writes = {expected_writes, w};
         parity_disk = (parity_disk == 0) ? disk_count - 1 : parity_disk - 1;
         stripe_no   = stripe_no + 1'b1;
         next_disk   = (parity_disk == 0) ? 1 : 0;
      endfunction

      function void check_transfer(block_write_type got);
         block_write_type exp;
         if (expected_writes.size() == 0) begin
            flag($sformatf("unexpected transfer disk=%0d stripe=%0d kind=%0d last=%0d",
                           got.disk, got.stripe, got.kind, got.last));
            return;
         end
         exp = expected_writes.pop_front();
         if (got.disk !== exp.disk || got.stripe !== exp.stripe ||
             got.kind !== exp.kind || got.last !== exp.last)
            flag($sformatf({"expected disk=%0d stripe=%0d kind=%0d last=%0d, ",
                            "got disk=%0d stripe=%0d kind=%0d last=%0d"},
                           exp.disk, exp.stripe, exp.kind, exp.last,
                           got.disk, got.stripe, got.kind, got.last));
      endfunction

      function void report_missing();
         block_write_type exp;
         while (expected_writes.size() != 0) begin
            exp = expected_writes.pop_front();
            flag($sformatf("missing transfer disk=%0d stripe=%0d kind=%0d last=%0d",
                           exp.disk, exp.stripe, exp.kind, exp.last));
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [LBA_W-1:0]        req_lba;
   logic                    rsp_valid;
   logic [DISK_OUT_W-1:0]   rsp_disk;
   logic [STRIPE_OUT_W-1:0] rsp_stripe;
   logic [KIND_W-1:0]       rsp_kind;
   logic                    rsp_last;
   logic                    csr_we;
   logic [CSR_W-1:0]        csr_wdata;

   placement_tracker_type tracker = new();
   int                    idle_pct;

   raid5_stripe_block_distributor #(
      .MAP_ENTRIES (SECTORS),
      .MAX_DISKS   (MAX_DISKS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_lba    (req_lba),
      .rsp_valid  (rsp_valid),
      .rsp_disk   (rsp_disk),
      .rsp_stripe (rsp_stripe),
      .rsp_kind   (rsp_kind),
      .rsp_last   (rsp_last),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Results are checked before the input of the same edge is noted, since a
   // sector taken at this edge cannot have produced a transfer yet.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_transfer('{rsp_disk, rsp_stripe, kind_type'(rsp_kind), rsp_last});
         if (start && !busy) tracker.note_sector(req_lba);
      end
   end

   task automatic send_sector(input logic [LBA_W-1:0] lba);
      start   <= 1'b1;
      req_lba <= lba;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start   <= 1'b0;
         req_lba <= LBA_W'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic drain_writes();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_disk_count(input logic [CSR_W-1:0] value);
      drain_writes();
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_disk_count(value);
   endtask

   function automatic logic [LBA_W-1:0] pick_lba();
      int n;
      n = tracker.written_lbas.size();
      if (n > 0 && $urandom_range(99) < 40)
         return tracker.written_lbas[$urandom_range(n - 1)];
      return LBA_W'($urandom_range(SECTORS - 1));
   endfunction

   initial begin
      logic [LBA_W-1:0] directed_lbas[$];
      logic [CSR_W-1:0] phase_disks[$];
      reset     = 1'b1;
      start     = 1'b0;
      req_lba   = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      idle_pct  = 7;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset disk count: extremes, repeats that hit the map, and enough new
      // sectors to walk the parity disk down through disk 0 and wrap.
      directed_lbas = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'hAAA, 12'h555, 12'hAAA};
      for (int i = 1; i <= 13; i++) directed_lbas = {directed_lbas, LBA_W'(i)};
      directed_lbas = {directed_lbas, 12'd0};
      foreach (directed_lbas[i]) send_sector(directed_lbas[i]);

      // Out-of-range counts on both sides, the legal extremes, and a write
      // in the middle of a stripe to restart the rotation.
      phase_disks = '{5'd0, 5'd31, 5'd16, 5'd2, 5'd1, 5'd17, 5'd3, 5'd9, 5'd15};
      phase_disks = {phase_disks, CSR_W'($urandom_range(0, 31))};
      phase_disks = {phase_disks, CSR_W'($urandom_range(0, 31))};
      foreach (phase_disks[p]) begin
         write_disk_count(phase_disks[p]);
         idle_pct = (p == 2) ? 0 : 7;
         repeat (PHASE_ITEMS) send_sector(pick_lba());
         if (p == 6) begin
            start <= 1'b0;
            @(posedge clock);
            write_disk_count(5'd5);
            repeat (PHASE_ITEMS / 2) send_sector(pick_lba());
         end
      end

      drain_writes();
      repeat (8) @(posedge clock);
      tracker.report_missing();
      if (tracker.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
